>>> hw/rtl/plc_area_memory_access_macros.svh
// Assertion helpers for the process image store.
`ifndef PLC_AREA_MEMORY_ACCESS_MACROS_SVH
`define PLC_AREA_MEMORY_ACCESS_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pam_pkg.sv
package pam_pkg;

  // Width of pool addresses and layout sums (covers pools up to 2^24 bytes).
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned PROD_W = 21;

  localparam logic [2:0] CFG_INPUT_BYTES  = 3'd0;
  localparam logic [2:0] CFG_OUTPUT_BYTES = 3'd1;
  localparam logic [2:0] CFG_MARKER_BYTES = 3'd2;
  localparam logic [2:0] CFG_BLOCK_COUNT  = 3'd3;
  localparam logic [2:0] CFG_BLOCK_BYTES  = 3'd4;

  localparam logic [1:0] AREA_INPUT  = 2'd0;
  localparam logic [1:0] AREA_OUTPUT = 2'd1;
  localparam logic [1:0] AREA_MARKER = 2'd2;
  localparam logic [1:0] AREA_BLOCK  = 2'd3;

  localparam logic [1:0] WIDTH_BIT   = 2'd0;
  localparam logic [1:0] WIDTH_BYTE  = 2'd1;
  localparam logic [1:0] WIDTH_WORD  = 2'd2;
  localparam logic [1:0] WIDTH_DWORD = 2'd3;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] input_bytes;
    logic [SIZE_W-1:0] output_bytes;
    logic [SIZE_W-1:0] marker_bytes;
    logic [7:0]        block_count;
    logic [SIZE_W-1:0] block_bytes;
  } pam_cfg_t;

  typedef struct packed {
    logic             ok;
    logic [SUM_W-1:0] addr;
  } pam_loc_t;

  // Access length in bytes; a bit access touches one byte.
  function automatic logic [2:0] pam_len(input logic [1:0] width);
    logic [2:0] len;
    unique case (width)
      WIDTH_BIT:   len = 3'd1;
      WIDTH_BYTE:  len = 3'd1;
      WIDTH_WORD:  len = 3'd2;
      WIDTH_DWORD: len = 3'd4;
      default:     len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

>>> hw/rtl/pam_ram.sv
module pam_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/pam_locate.sv
module pam_locate #(
  parameter int unsigned POOL_BYTES = 4096
) (
  input  logic               clk_i,
  input  pam_pkg::pam_cfg_t  cfg_i,
  input  logic [1:0]         area_i,
  input  logic [7:0]         block_i,
  input  logic [11:0]        offset_i,
  input  logic [1:0]         width_i,
  output pam_pkg::pam_loc_t  loc_o
);

  localparam int unsigned SW = pam_pkg::SUM_W;

  logic [SW-1:0]              base_d, base_q;
  logic [pam_pkg::SIZE_W-1:0] size_d, size_q;
  logic                       bad_d, bad_q;
  logic [SW-1:0]              sum_io, sum_iom;
  logic [pam_pkg::PROD_W-1:0] blk_prod;
  logic [7:0]                 blk_idx;

  // First step: area base and size from the layout.
  always_comb begin
    sum_io   = SW'(cfg_i.input_bytes) + SW'(cfg_i.output_bytes);
    sum_iom  = sum_io + SW'(cfg_i.marker_bytes);
    blk_idx  = block_i - 8'd1;
    blk_prod = pam_pkg::PROD_W'(blk_idx) * pam_pkg::PROD_W'(cfg_i.block_bytes);
    bad_d    = 1'b0;
    unique case (area_i)
      pam_pkg::AREA_INPUT: begin
        base_d = '0;
        size_d = cfg_i.input_bytes;
      end
      pam_pkg::AREA_OUTPUT: begin
        base_d = SW'(cfg_i.input_bytes);
        size_d = cfg_i.output_bytes;
      end
      pam_pkg::AREA_MARKER: begin
        base_d = sum_io;
        size_d = cfg_i.marker_bytes;
      end
      default: begin
        base_d = sum_iom + SW'(blk_prod);
        size_d = cfg_i.block_bytes;
        bad_d  = (block_i == 8'd0) || (block_i > cfg_i.block_count);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    size_q <= size_d;
    bad_q  <= bad_d;
  end

  logic [2:0]                 len;
  logic [pam_pkg::SIZE_W-1:0] area_end;
  logic [SW-1:0]              pool_end;

  // Second step: bounds against the area and the pool.
  always_comb begin
    len        = pam_pkg::pam_len(width_i);
    area_end   = pam_pkg::SIZE_W'(offset_i) + pam_pkg::SIZE_W'(len);
    pool_end   = base_q + SW'(offset_i) + SW'(len);
    loc_o.ok   = !bad_q && (area_end <= size_q) && (pool_end <= SW'(POOL_BYTES));
    loc_o.addr = base_q + SW'(offset_i);
  end

endmodule

>>> hw/rtl/plc_area_memory_access.sv
// After an input beat is accepted, the sequencer steps through S_BASE, S_CHECK and
// S_RESP; a new beat is taken only back in S_IDLE, after the locate, bank read and
// write-back steps of the shared byte-banked store, and a stalled result holds it in S_RESP.
// Reset: layout registers clear to zero; the store is then zeroed by a pass over
// all ROWS rows, one row of all four banks a cycle, with in_ready_o low.
module plc_area_memory_access #(
  parameter int unsigned POOL_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [1:0]  access_width_i,
  input  logic [1:0]  area_select_i,
  input  logic [7:0]  block_number_i,
  input  logic [11:0] byte_offset_i,
  input  logic [2:0]  bit_index_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        access_ok_o
);

  `include "plc_area_memory_access_macros.svh"

  localparam int unsigned SW   = pam_pkg::SUM_W;
  localparam int unsigned ROWS = (POOL_BYTES + 3) / 4;
  localparam int unsigned RW   = $clog2(ROWS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BASE,
    S_CHECK,
    S_RESP
  } state_e;

  state_e            state_q;
  logic              clr_q;
  logic [RW-1:0]     clr_row_q;
  pam_pkg::pam_cfg_t cfg_q;

  logic        cmd_q;
  logic [1:0]  width_q;
  logic [1:0]  area_q;
  logic [7:0]  block_q;
  logic [11:0] offset_q;
  logic [2:0]  bit_q;
  logic [31:0] wdata_q;
  logic        ok_q;
  logic [SW-1:0] addr_q;

  logic        out_valid_q;
  logic [31:0] read_data_q;
  logic        access_ok_q;

  pam_pkg::pam_loc_t loc;
  logic              in_fire;
  logic              resp_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !clr_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign resp_fire   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // Layout registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pam_pkg::CFG_INPUT_BYTES:  cfg_q.input_bytes  <= cfg_data_i;
        pam_pkg::CFG_OUTPUT_BYTES: cfg_q.output_bytes <= cfg_data_i;
        pam_pkg::CFG_MARKER_BYTES: cfg_q.marker_bytes <= cfg_data_i;
        pam_pkg::CFG_BLOCK_COUNT:  cfg_q.block_count  <= cfg_data_i[7:0];
        pam_pkg::CFG_BLOCK_BYTES:  cfg_q.block_bytes  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pam_locate #(
    .POOL_BYTES(POOL_BYTES)
  ) u_locate (
    .clk_i   (clk_i),
    .cfg_i   (cfg_q),
    .area_i  (area_q),
    .block_i (block_q),
    .offset_i(offset_q),
    .width_i (width_q),
    .loc_o   (loc)
  );

  // Byte banks: bank b holds pool bytes whose address is b modulo 4.
  logic [SW-1:0]   sel_addr;
  logic [SW-3:0]   row_full [4];
  logic [RW-1:0]   bank_row [4];
  logic [7:0]      bank_rd  [4];
  logic [7:0]      bank_wd  [4];
  logic            bank_we  [4];
  logic [7:0]      wbyte    [4];
  logic            wr_en    [4];
  logic [7:0]      rbyte    [4];
  logic [1:0]      lo;
  logic [2:0]      len;
  logic [31:0]     rd_val;
  logic [7:0]      bit_mask;
  logic [1:0]      idx      [4];

  assign sel_addr = (state_q == S_CHECK) ? loc.addr : addr_q;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      row_full[b] = sel_addr[SW-1:2] + ((2'(b) < sel_addr[1:0]) ? (SW-2)'(1) : '0);
      bank_row[b] = clr_q ? clr_row_q : row_full[b][RW-1:0];
    end
  end

  // Assemble read data and write-back bytes from the bank outputs.
  always_comb begin
    lo       = addr_q[1:0];
    len      = pam_pkg::pam_len(width_q);
    bit_mask = 8'd1 << bit_q;
    rd_val   = '0;
    for (int i = 0; i < 4; i++) begin
      rbyte[i] = bank_rd[2'(lo + 2'(i))];
      if (3'(i) < len) begin
        rd_val[8*i +: 8] = rbyte[i];
      end
    end
    if (width_q == pam_pkg::WIDTH_BIT) begin
      rd_val = {31'd0, rbyte[0][bit_q]};
    end
    for (int b = 0; b < 4; b++) begin
      idx[b] = 2'(2'(b) - lo);
      if (width_q == pam_pkg::WIDTH_BIT) begin
        wbyte[b] = wdata_q[0] ? (bank_rd[b] | bit_mask) : (bank_rd[b] & ~bit_mask);
      end else begin
        wbyte[b] = wdata_q[8*idx[b] +: 8];
      end
      wr_en[b]   = resp_fire && ok_q && (cmd_q == pam_pkg::CMD_WRITE)
                   && (3'(idx[b]) < len);
      bank_we[b] = clr_q || wr_en[b];
      bank_wd[b] = clr_q ? 8'd0 : wbyte[b];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    pam_ram #(
      .Width(8),
      .Depth(ROWS)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (bank_we[g]),
      .re_i   (state_q == S_CHECK),
      .addr_i (bank_row[g]),
      .wdata_i(bank_wd[g]),
      .rdata_o(bank_rd[g])
    );
  end

  // Sequencer, clearing pass and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clr_q       <= 1'b1;
      clr_row_q   <= '0;
      out_valid_q <= 1'b0;
      read_data_q <= '0;
      access_ok_q <= 1'b0;
      cmd_q       <= 1'b0;
      width_q     <= '0;
      area_q      <= '0;
      block_q     <= '0;
      offset_q    <= '0;
      bit_q       <= '0;
      wdata_q     <= '0;
      ok_q        <= 1'b0;
      addr_q      <= '0;
    end else begin
      if (clr_q) begin
        clr_row_q <= clr_row_q + RW'(1);
        if (clr_row_q == RW'(ROWS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      // Load a new beat, or drop the one just taken.
      if (resp_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q    <= command_i;
            width_q  <= access_width_i;
            area_q   <= area_select_i;
            block_q  <= block_number_i;
            offset_q <= byte_offset_i;
            bit_q    <= bit_index_i;
            wdata_q  <= write_data_i;
            state_q  <= S_BASE;
          end
        end
        S_BASE: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          ok_q    <= loc.ok;
          addr_q  <= loc.addr;
          state_q <= S_RESP;
        end
        S_RESP: begin
          // Hold until the result register is free.
          if (resp_fire) begin
            access_ok_q <= ok_q;
            read_data_q <= (ok_q && (cmd_q != pam_pkg::CMD_WRITE)) ? rd_val : 32'd0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign access_ok_o = access_ok_q;

  `PAM_ASSERT_ALWAYS(a_fail_zero,
    !(out_valid_o && !access_ok_o) || (read_data_o == 32'd0),
    "rejected access returned data")
  `PAM_ASSERT_NEXT(a_accept_starts, in_fire, (state_q == S_BASE) && !clr_q,
    "accepted beat did not start locate")
  `PAM_ASSERT_NEXT(a_resp_delivers, resp_fire, out_valid_q && (state_q == S_IDLE),
    "response not loaded into result register")

endmodule

>>> tb/tb_plc_area_memory_access.sv
module tb_plc_area_memory_access;

  localparam int unsigned POOL_BYTES   = 4096;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned PHASE_ITEMS  = 115;
  localparam int unsigned SETTLE       = 8;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  width;
    logic [1:0]  area;
    logic [7:0]  blk;
    logic [11:0] off;
    logic [2:0]  bit_sel;
    logic [31:0] wdata;
  } access_t;

  // Shadow of the process image: layout registers, byte pool, and the
  // read results still owed by the block.
  class access_scoreboard;
    typedef struct {
      logic [31:0] data;
      logic        ok;
    } result_t;

    logic [7:0]  pool [POOL_BYTES];
    int unsigned in_bytes, out_bytes, mk_bytes, blk_cnt, blk_bytes;
    result_t     expected_q [$];
    int unsigned errors;

    function new();
      foreach (pool[i]) pool[i] = 8'h00;
      in_bytes  = 0;
      out_bytes = 0;
      mk_bytes  = 0;
      blk_cnt   = 0;
      blk_bytes = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [12:0] val);
      case (idx)
        pam_pkg::CFG_INPUT_BYTES:  in_bytes  = 32'(val);
        pam_pkg::CFG_OUTPUT_BYTES: out_bytes = 32'(val);
        pam_pkg::CFG_MARKER_BYTES: mk_bytes  = 32'(val);
        pam_pkg::CFG_BLOCK_COUNT:  blk_cnt   = 32'(val[7:0]);
        pam_pkg::CFG_BLOCK_BYTES:  blk_bytes = 32'(val);
        default: ;
      endcase
    endfunction

    function int unsigned region_bytes(logic [1:0] area);
      case (area)
        pam_pkg::AREA_INPUT:  return in_bytes;
        pam_pkg::AREA_OUTPUT: return out_bytes;
        pam_pkg::AREA_MARKER: return mk_bytes;
        default:              return blk_bytes;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted access to the shadow pool and queue its result.
    function void note_access(access_t a);
      int unsigned len, base, addr;
      bit          ok;
      result_t     r;
      len  = (a.width == pam_pkg::WIDTH_BIT) ? 1 : (1 << (a.width - 1));
      ok   = 1'b1;
      base = 0;
      case (a.area)
        pam_pkg::AREA_INPUT:  base = 0;
        pam_pkg::AREA_OUTPUT: base = in_bytes;
        pam_pkg::AREA_MARKER: base = in_bytes + out_bytes;
        default: begin
          if (a.blk == 0 || a.blk > blk_cnt) ok = 1'b0;
          else base = in_bytes + out_bytes + mk_bytes + (a.blk - 1) * blk_bytes;
        end
      endcase
      if (a.off + len > region_bytes(a.area)) ok = 1'b0;
      if (base + a.off + len > POOL_BYTES) ok = 1'b0;
      r.data = 32'h0;
      r.ok   = ok;
      if (ok) begin
        addr = base + a.off;
        if (a.cmd == pam_pkg::CMD_WRITE) begin
          if (a.width == pam_pkg::WIDTH_BIT) pool[addr][a.bit_sel] = a.wdata[0];
          else for (int i = 0; i < len; i++) pool[addr + i] = a.wdata[8*i +: 8];
        end else begin
          if (a.width == pam_pkg::WIDTH_BIT) r.data = {31'b0, pool[addr][a.bit_sel]};
          else for (int i = 0; i < len; i++) r.data[8*i +: 8] = pool[addr + i];
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] data, logic ok);
      result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result data %h ok %b with no access pending", $time, data, ok);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data) begin
        $display("%0t: read_data expected %h actual %h", $time, e.data, data);
        errors++;
      end
      if (ok !== e.ok) begin
        $display("%0t: access_ok expected %b actual %b", $time, e.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i    = '0;
  logic [12:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        command_i      = 1'b0;
  logic [1:0]  access_width_i = '0;
  logic [1:0]  area_select_i  = '0;
  logic [7:0]  block_number_i = '0;
  logic [11:0] byte_offset_i  = '0;
  logic [2:0]  bit_index_i    = '0;
  logic [31:0] write_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [31:0] read_data_o;
  logic        access_ok_o;

  access_scoreboard sb = new();
  bit               steady = 1'b0;
  int unsigned      cycles = 0;

  plc_area_memory_access #(.POOL_BYTES(POOL_BYTES)) DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("** plc_area_memory_access: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) out_ready_i <= steady || ($urandom_range(0, 99) >= 10);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(read_data_o, access_ok_o);
  end

  function automatic access_t make_access(logic cmd, logic [1:0] width, logic [1:0] area,
                                          logic [7:0] blk, logic [11:0] off,
                                          logic [2:0] bit_sel, logic [31:0] wdata);
    access_t a;
    a = '{cmd, width, area, blk, off, bit_sel, wdata};
    return a;
  endfunction

  // Mostly land inside the selected area (edge included), else anything goes.
  function automatic access_t random_access();
    access_t     a;
    int unsigned lim;
    a.cmd     = 1'($urandom_range(0, 1));
    a.width   = 2'($urandom_range(0, 3));
    a.area    = 2'($urandom_range(0, 3));
    a.blk     = 8'($urandom_range(0, 255));
    a.off     = 12'($urandom_range(0, 4095));
    a.bit_sel = 3'($urandom_range(0, 7));
    a.wdata   = $urandom;
    if ($urandom_range(0, 99) < 85) begin
      if (a.area == pam_pkg::AREA_BLOCK && sb.blk_cnt != 0) begin
        a.blk = 8'($urandom_range(1, sb.blk_cnt));
      end
      lim   = sb.region_bytes(a.area);
      if (lim > 4095) lim = 4095;
      a.off = 12'($urandom_range(0, lim));
    end
    return a;
  endfunction

  task automatic send_access(input access_t a);
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= a.cmd;
    access_width_i <= a.width;
    area_select_i  <= a.area;
    block_number_i <= a.blk;
    byte_offset_i  <= a.off;
    bit_index_i    <= a.bit_sel;
    write_data_i   <= a.wdata;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(a);
  endtask

  // Drop valid, let every owed result come back, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic program_layout(input logic [12:0] v_in, input logic [12:0] v_out,
                                input logic [12:0] v_mk, input logic [12:0] v_cnt,
                                input logic [12:0] v_bb, input bit with_unused);
    logic [2:0]  idx_q [$];
    logic [12:0] val_q [$];
    idx_q = '{pam_pkg::CFG_INPUT_BYTES, pam_pkg::CFG_OUTPUT_BYTES,
              pam_pkg::CFG_MARKER_BYTES, pam_pkg::CFG_BLOCK_COUNT,
              pam_pkg::CFG_BLOCK_BYTES};
    val_q = '{v_in, v_out, v_mk, v_cnt, v_bb};
    if (with_unused) begin
      for (int k = int'(pam_pkg::CFG_BLOCK_BYTES) + 1; k < 8; k++) begin
        idx_q.push_back(3'(k));
        val_q.push_back(13'($urandom_range(0, 8191)));
      end
    end
    foreach (idx_q[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_q[i];
      cfg_data_i  <= val_q[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(idx_q[i], val_q[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  logic [12:0] layouts [6][5] = '{
    '{13'd16, 13'd16, 13'd32, 13'd3, 13'd8},
    '{13'd4096, 13'd0, 13'd0, 13'd0, 13'd0},
    '{13'd100, 13'd200, 13'd300, 13'd255, 13'd13},
    '{13'd24, 13'd40, 13'd64, 13'd6, 13'd16},
    '{13'd1000, 13'd1000, 13'd1000, 13'd200, 13'd8},
    '{13'd8191, 13'd8191, 13'd8191, 13'd8191, 13'd8191}
  };

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset layout: every area is empty.
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_BYTE, pam_pkg::AREA_INPUT,
                            8'd0, 12'd0, 3'd0, 32'h0));
    send_access(make_access(pam_pkg::CMD_WRITE, pam_pkg::WIDTH_BIT, pam_pkg::AREA_BLOCK,
                            8'd1, 12'd0, 3'd0, 32'h1));
    drain();

    program_layout(13'd16, 13'd16, 13'd32, 13'd3, 13'd8, 1'b1);
    send_access(make_access(pam_pkg::CMD_WRITE, pam_pkg::WIDTH_DWORD, pam_pkg::AREA_INPUT,
                            8'd0, 12'd0, 3'd0, 32'hFFFF_FFFF));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_DWORD, pam_pkg::AREA_INPUT,
                            8'd0, 12'd0, 3'd0, 32'h0));
    // Clearing one bit leaves the rest of the byte.
    send_access(make_access(pam_pkg::CMD_WRITE, pam_pkg::WIDTH_BIT, pam_pkg::AREA_INPUT,
                            8'd0, 12'd1, 3'd7, 32'hFFFF_FFFE));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_DWORD, pam_pkg::AREA_INPUT,
                            8'd0, 12'd0, 3'd0, 32'h0));
    send_access(make_access(pam_pkg::CMD_WRITE, pam_pkg::WIDTH_BIT, pam_pkg::AREA_OUTPUT,
                            8'd0, 12'd15, 3'd0, 32'h1));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_BIT, pam_pkg::AREA_OUTPUT,
                            8'd0, 12'd15, 3'd0, 32'h0));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_BIT, pam_pkg::AREA_OUTPUT,
                            8'd0, 12'd15, 3'd7, 32'h0));
    send_access(make_access(pam_pkg::CMD_WRITE, pam_pkg::WIDTH_WORD, pam_pkg::AREA_MARKER,
                            8'd0, 12'd30, 3'd0, 32'hA5A5_1234));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_WORD, pam_pkg::AREA_MARKER,
                            8'd0, 12'd30, 3'd0, 32'h0));
    // Runs one byte past the marker area.
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_DWORD, pam_pkg::AREA_MARKER,
                            8'd0, 12'd29, 3'd0, 32'h0));
    send_access(make_access(pam_pkg::CMD_WRITE, pam_pkg::WIDTH_DWORD, pam_pkg::AREA_BLOCK,
                            8'd3, 12'd4, 3'd0, 32'hDEAD_BEEF));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_DWORD, pam_pkg::AREA_BLOCK,
                            8'd3, 12'd4, 3'd0, 32'h0));
    // Bad block numbers.
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_BYTE, pam_pkg::AREA_BLOCK,
                            8'd0, 12'd0, 3'd0, 32'h0));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_BYTE, pam_pkg::AREA_BLOCK,
                            8'd4, 12'd0, 3'd0, 32'h0));
    send_access(make_access(pam_pkg::CMD_WRITE, pam_pkg::WIDTH_BYTE, pam_pkg::AREA_BLOCK,
                            8'd255, 12'd0, 3'd0, 32'h5A));
    // Block number is ignored outside the data blocks.
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_BYTE, pam_pkg::AREA_INPUT,
                            8'd200, 12'd0, 3'd0, 32'h0));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_BIT, pam_pkg::AREA_INPUT,
                            8'd0, 12'd4095, 3'd7, 32'h0));
    drain();

    // Layout larger than the pool: only the pool bound stops the access.
    program_layout(13'd8191, 13'd8191, 13'd8191, 13'd255, 13'd8191, 1'b0);
    send_access(make_access(pam_pkg::CMD_WRITE, pam_pkg::WIDTH_DWORD, pam_pkg::AREA_INPUT,
                            8'd0, 12'd4092, 3'd0, 32'h0F0F_F0F0));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_DWORD, pam_pkg::AREA_INPUT,
                            8'd0, 12'd4092, 3'd0, 32'h0));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_DWORD, pam_pkg::AREA_INPUT,
                            8'd0, 12'd4093, 3'd0, 32'h0));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_BYTE, pam_pkg::AREA_OUTPUT,
                            8'd0, 12'd0, 3'd0, 32'h0));
    send_access(make_access(pam_pkg::CMD_READ, pam_pkg::WIDTH_BYTE, pam_pkg::AREA_BLOCK,
                            8'd1, 12'd0, 3'd0, 32'h0));
    drain();

    foreach (layouts[p]) begin
      program_layout(layouts[p][0], layouts[p][1], layouts[p][2], layouts[p][3],
                     layouts[p][4], p == 3);
      steady = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) send_access(random_access());
      steady = 1'b0;
      drain();
    end

    program_layout(13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 1'b0);
    for (int n = 0; n < 20; n++) send_access(random_access());
    drain();

    if (sb.errors == 0) begin
      $display("** plc_area_memory_access: PASSED **");
    end else begin
      $display("** plc_area_memory_access: FAILED **");
    end
    $finish;
  end

endmodule
